[src/x86_byte_alu_with_flags_assert.svh]
// Assertion macros shared by the RTL of the byte ALU.
// Each macro checks on the rising edge of i_clk and is held off while reset is low.
`ifndef X86_BYTE_ALU_WITH_FLAGS_ASSERT_SVH
`define X86_BYTE_ALU_WITH_FLAGS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define X86A_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define X86A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/x86alu_pkg.sv]
`default_nettype none

package x86alu_pkg;

    // Operation codes.
    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_ADC   = 4'd1;
    localparam logic [3:0] FUNC_SUB   = 4'd2;
    localparam logic [3:0] FUNC_CMP   = 4'd3;
    localparam logic [3:0] FUNC_AND   = 4'd4;
    localparam logic [3:0] FUNC_OR    = 4'd5;
    localparam logic [3:0] FUNC_XOR   = 4'd6;
    localparam logic [3:0] FUNC_DAA   = 4'd7;
    localparam logic [3:0] FUNC_ROL16 = 4'd8;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_HIGH_LIM = 8'h99;
    localparam logic [3:0] DAA_LOW_LIM  = 4'd9;

    // Flag register, laid out with CF in bit 0 and OF in bit 5.
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flags;

    // Even parity of a byte: high when the number of ones is even.
    function automatic logic even_parity(input logic [7:0] value);
        even_parity = ~(^value);
    endfunction

endpackage

`default_nettype wire

[src/x86alu_core.sv]
`default_nettype none

module x86alu_core (
    input  wire logic [3:0]          i_func,
    input  wire logic [15:0]         i_operand_a,
    input  wire logic [7:0]          i_operand_b,
    input  wire x86alu_pkg::t_flags  i_flags,
    output logic [15:0]              o_result,
    output logic                     o_write_back,
    output x86alu_pkg::t_flags       o_flags
);
    import x86alu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [8:0]  daa_low_sum;
    logic [7:0]  daa_step;
    logic [7:0]  daa_byte;
    logic        daa_low;
    logic        daa_high;
    logic [31:0] rot_wide;
    logic [15:0] rot_word;
    logic [7:0]  logic_byte;

    assign a = i_operand_a[7:0];
    assign b = i_operand_b;

    // Adder with optional carry in, and subtractor with borrow out.
    assign sum  = {1'b0, a} + {1'b0, b}
                + {8'd0, ((i_func == FUNC_ADC) ? i_flags.cf : 1'b0)};
    assign diff = {1'b0, a} - {1'b0, b};

    // Decimal adjust: low nibble step, then high nibble step, both tested on the original byte.
    assign daa_low     = (a[3:0] > DAA_LOW_LIM) || i_flags.af;
    assign daa_high    = (a > DAA_HIGH_LIM) || i_flags.cf;
    assign daa_low_sum = {1'b0, a} + {1'b0, DAA_LOW_ADJ};
    assign daa_step    = daa_low ? daa_low_sum[7:0] : a;
    assign daa_byte    = daa_high ? (daa_step + DAA_HIGH_ADJ) : daa_step;

    // Barrel rotate of the full word by the count modulo sixteen.
    assign rot_wide = {i_operand_a, i_operand_a} << i_operand_b[3:0];
    assign rot_word = rot_wide[31:16];

    // Bitwise operations.
    always_comb begin
        case (i_func)
            FUNC_AND: logic_byte = a & b;
            FUNC_OR:  logic_byte = a | b;
            default:  logic_byte = a ^ b;
        endcase
    end

    // Result and flag selection.
    always_comb begin
        o_result     = 16'd0;
        o_write_back = 1'b1;
        o_flags      = i_flags;
        case (i_func)
            FUNC_ADD, FUNC_ADC: begin
                o_result   = {8'd0, sum[7:0]};
                o_flags.cf = sum[8];
                o_flags.af = a[4] ^ b[4] ^ sum[4];
                o_flags.of = (a[7] ^ sum[7]) & (b[7] ^ sum[7]);
                o_flags.zf = (sum[7:0] == 8'd0);
                o_flags.sf = sum[7];
                o_flags.pf = even_parity(sum[7:0]);
            end
            FUNC_SUB, FUNC_CMP: begin
                o_result     = {8'd0, diff[7:0]};
                o_write_back = (i_func != FUNC_CMP);
                o_flags.cf   = diff[8];
                o_flags.af   = a[4] ^ b[4] ^ diff[4];
                o_flags.of   = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
                o_flags.zf   = (diff[7:0] == 8'd0);
                o_flags.sf   = diff[7];
                o_flags.pf   = even_parity(diff[7:0]);
            end
            FUNC_AND, FUNC_OR, FUNC_XOR: begin
                o_result   = {8'd0, logic_byte};
                o_flags.cf = 1'b0;
                o_flags.of = 1'b0;
                o_flags.zf = (logic_byte == 8'd0);
                o_flags.sf = logic_byte[7];
                o_flags.pf = even_parity(logic_byte);
            end
            FUNC_DAA: begin
                o_result   = {8'd0, daa_byte};
                o_flags.cf = daa_high;
                o_flags.af = daa_low;
                o_flags.zf = (daa_byte == 8'd0);
                o_flags.sf = daa_byte[7];
                o_flags.pf = even_parity(daa_byte);
            end
            FUNC_ROL16: begin
                o_result = rot_word;
                // A zero count leaves every flag alone.
                if (i_operand_b != 8'd0) begin
                    o_flags.cf = rot_word[0];
                    o_flags.of = rot_word[15] ^ rot_word[0];
                end
            end
            default: begin
                o_result     = 16'd0;
                o_write_back = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/x86_byte_alu_with_flags.sv]
// A result is shown once its beat has passed through the input register and then the output register.
// Throughput: one beat per cycle while i_out_stall does not hold the output; the flag register closes a loop
// from the ALU back to its own flag inputs, so back-to-back items see fresh flags.
// Reset (synchronous, active low) clears both valid bits and all six flags of the flag register.
`default_nettype none

module x86_byte_alu_with_flags (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_func,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [7:0]  i_operand_b,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_result,
    output logic             o_write_back,
    output logic             o_carry_flag,
    output logic             o_parity_flag,
    output logic             o_aux_flag,
    output logic             o_zero_flag,
    output logic             o_sign_flag,
    output logic             o_overflow_flag
);
    import x86alu_pkg::*;

`include "x86_byte_alu_with_flags_assert.svh"

    logic        r_s1_valid;
    logic [3:0]  r_s1_func;
    logic [15:0] r_s1_operand_a;
    logic [7:0]  r_s1_operand_b;

    logic        r_out_valid;
    logic [15:0] r_out_result;
    logic        r_out_write_back;
    t_flags      r_out_flags;

    t_flags      r_flags;
    t_flags      n_flags;
    logic [15:0] core_result;
    logic        core_write_back;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;

    // Handshake: the output register frees when empty or taken; stage one
    // moves into it whenever it frees.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func      <= i_func;
            r_s1_operand_a <= i_operand_a;
            r_s1_operand_b <= i_operand_b;
        end
    end

    // ALU and flag logic.
    x86alu_core u_core (
        .i_func       (r_s1_func),
        .i_operand_a  (r_s1_operand_a),
        .i_operand_b  (r_s1_operand_b),
        .i_flags      (r_flags),
        .o_result     (core_result),
        .o_write_back (core_write_back),
        .o_flags      (n_flags)
    );

    // Flag register updates as each item passes into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (s1_fire) begin
            r_flags <= n_flags;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_result     <= core_result;
            r_out_write_back <= core_write_back;
            r_out_flags      <= n_flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result        = r_out_result;
    assign o_write_back    = r_out_write_back;
    assign o_carry_flag    = r_out_flags.cf;
    assign o_parity_flag   = r_out_flags.pf;
    assign o_aux_flag      = r_out_flags.af;
    assign o_zero_flag     = r_out_flags.zf;
    assign o_sign_flag     = r_out_flags.sf;
    assign o_overflow_flag = r_out_flags.of;

    // Checks on the flag loop and the stage handshake.
    `X86A_ASSERT_NEXT(a_flags_hold, !s1_fire, $stable(r_flags),
        "Flag register changed with no item passing")
    `X86A_ASSERT_SAME(a_out_flags_match, r_out_valid, r_out_flags == r_flags,
        "Shown flags differ from the flag register")
    `X86A_ASSERT_NEXT(a_cmp_no_write, s1_fire && (r_s1_func == FUNC_CMP), !o_write_back,
        "Compare result marked for write back")
    `X86A_ASSERT_SAME(a_stall_when_blocked, r_s1_valid && !s1_fire, o_in_stall,
        "Input taken while stage one is blocked")

endmodule

`default_nettype wire
